@@ src/tpcs_pkg.sv @@
// Package for the tracker pattern channel scanner.
// Request, status and register index codes, field widths and pattern constants; no dependencies.
`default_nettype none

package tpcs_pkg;

    // Field widths
    localparam int unsigned REQ_W      = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned PAT_W      = 8;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned NUM_CHAN   = 32;
    localparam int unsigned CHAN_W     = 5;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned ROW_W      = 7;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 56;

    // Rows in one pattern
    localparam int unsigned DEF_ROWS_PER_PATTERN = 64;

    // Request kinds (input tuser)
    localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END   = 2'd2;

    // Result kinds (output tuser)
    localparam logic [STAT_W-1:0] ST_ACCEPTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_COMPLETE = 2'd1;
    localparam logic [STAT_W-1:0] ST_CORRUPT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_SUMMARY  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_LO     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_MID_LO = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_MID_HI = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SET_HI     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GVOL       = 3'd4;

    // Pattern constants
    localparam logic [BYTE_W-1:0] SETTING_LIMIT = 8'd16;
    localparam logic [BYTE_W-1:0] CMD_GVOL      = 8'd22;
    localparam logic [BYTE_W-1:0] GVOL_MAX_INFO = 8'h40;
    localparam logic [BYTE_W-1:0] GVOL_LOW      = 8'd30;
    localparam logic [BYTE_W-1:0] GVOL_FORCED   = 8'd64;

endpackage

`default_nettype wire

@@ src/tracker_pattern_channel_scanner.sv @@
// An accepted input word's result word reaches the master side in the next cycle.
// Throughput: one input word per cycle while results are taken; the single output
// register holds a result; the next word is accepted as soon as the master takes it.
// Reset (synchronous, active low): parser idle, used-channel mask clear, volume force flag
// set, all channels enabled, header volume zero, no result pending.
// Top level of the tracker pattern channel scanner; uses tpcs_pkg.
`default_nettype none

module tracker_pattern_channel_scanner #(
    parameter int unsigned ROWS_PER_PATTERN = tpcs_pkg::DEF_ROWS_PER_PATTERN
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire [tpcs_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire [tpcs_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // input stream
    input  wire                               i_s_tvalid,
    output logic                              o_s_tready,
    // data_byte[7:0], pattern_length[23:8], pattern_number[31:24]
    input  wire [tpcs_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // req_type[1:0]
    input  wire [tpcs_pkg::REQ_W-1:0]         i_s_tuser,
    // result stream
    output logic                              o_m_tvalid,
    input  wire                               i_m_tready,
    // wants_bytes[0], used_channel_mask[32:1], used_channel_count[38:33],
    // global_volume[46:39], corrupt_pattern[54:47], zero[55]
    output logic [tpcs_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // status[1:0]
    output logic [tpcs_pkg::STAT_W-1:0]       o_m_tuser
);
    import tpcs_pkg::*;

    localparam logic [ROW_W-1:0] ROWS = ROW_W'(ROWS_PER_PATTERN);

    typedef enum logic [2:0] {
        PH_IDLE, PH_FLAG, PH_SKIP, PH_CMD, PH_INFO, PH_DONE, PH_BAD
    } t_phase;

    // configuration state: enable bit per channel (settings byte below limit)
    logic [NUM_CHAN-1:0] r_chan_en;
    logic [BYTE_W-1:0]   r_hdr_gvol;

    // parser state
    t_phase              r_phase,  n_phase;
    logic [1:0]          r_skip,   n_skip;
    logic [CHAN_W-1:0]   r_chan,   n_chan;
    logic [BYTE_W-1:0]   r_cmd,    n_cmd;
    logic                r_has_cmd, n_has_cmd;
    logic [ROW_W-1:0]    r_row,    n_row;
    logic [LEN_W-1:0]    r_used,   n_used;
    logic [LEN_W-1:0]    r_len,    n_len;
    logic [PAT_W-1:0]    r_pat,    n_pat;
    logic [NUM_CHAN-1:0] r_mask,   n_mask;
    logic                r_vforce, n_vforce;

    // output register
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [STAT_W-1:0]   r_out_stat;

    // result of the current word
    logic [STAT_W-1:0]   w_stat;
    logic                w_wants;
    logic [NUM_CHAN-1:0] w_mask;
    logic [COUNT_W-1:0]  w_count;
    logic [BYTE_W-1:0]   w_gvol;
    logic [PAT_W-1:0]    w_bad;

    logic                w_accept;
    logic [REQ_W-1:0]    w_req;
    logic [BYTE_W-1:0]   w_byte;
    logic                w_taking;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_req      = i_s_tuser;
    assign w_byte     = i_s_tdata[7:0];
    assign w_taking   = (r_phase == PH_FLAG) || (r_phase == PH_SKIP) ||
                        (r_phase == PH_CMD)  || (r_phase == PH_INFO);

    // next state and result for one word
    always_comb begin
        logic [1:0]        skip_v;
        logic [CHAN_W-1:0] ch_v;
        logic              fin_v;
        logic [BYTE_W-1:0] g_v;

        n_phase   = r_phase;
        n_skip    = r_skip;
        n_chan    = r_chan;
        n_cmd     = r_cmd;
        n_has_cmd = r_has_cmd;
        n_row     = r_row;
        n_used    = r_used;
        n_len     = r_len;
        n_pat     = r_pat;
        n_mask    = r_mask;
        n_vforce  = r_vforce;
        w_stat    = ST_ACCEPTED;
        w_gvol    = '0;
        w_bad     = '0;
        skip_v    = '0;
        ch_v      = r_chan;
        fin_v     = 1'b0;
        g_v       = r_hdr_gvol;

        if (w_req == REQ_BEGIN) begin
            n_len     = i_s_tdata[23:8];
            n_pat     = i_s_tdata[31:24];
            n_used    = '0;
            n_row     = '0;
            n_skip    = '0;
            n_has_cmd = 1'b0;
            n_cmd     = '0;
            n_chan    = '0;
            n_phase   = PH_FLAG;
            if (i_s_tdata[23:8] == '0) begin
                n_phase = PH_BAD;
                w_stat  = ST_CORRUPT;
            end
        end else if (w_req == REQ_DATA && w_taking) begin
            n_used = r_used + 1'b1;
            unique case (r_phase)
                PH_FLAG: begin
                    if (w_byte == '0) begin
                        n_row = r_row + 1'b1;
                        if (n_row >= ROWS) begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        ch_v      = w_byte[4:0];
                        skip_v    = {w_byte[5], 1'b0} + {1'b0, w_byte[6]};
                        n_chan    = ch_v;
                        n_skip    = skip_v;
                        n_has_cmd = w_byte[7];
                        if (skip_v != '0)  n_phase = PH_SKIP;
                        else if (w_byte[7]) n_phase = PH_CMD;
                        else               fin_v   = 1'b1;
                    end
                end
                PH_SKIP: begin
                    skip_v = r_skip - 1'b1;
                    n_skip = skip_v;
                    if (skip_v != '0)  n_phase = PH_SKIP;
                    else if (r_has_cmd) n_phase = PH_CMD;
                    else               fin_v   = 1'b1;
                end
                PH_CMD: begin
                    n_cmd   = w_byte;
                    n_phase = PH_INFO;
                end
                default: begin
                    if (r_cmd == CMD_GVOL && w_byte >= 8'd1 && w_byte <= GVOL_MAX_INFO) begin
                        n_vforce = 1'b0;
                    end
                    fin_v = 1'b1;
                end
            endcase
            // completed event marks its channel when enabled
            if (fin_v) begin
                n_mask[ch_v] = r_mask[ch_v] | r_chan_en[ch_v];
                n_phase      = PH_FLAG;
            end
            if (n_phase == PH_DONE) begin
                w_stat = ST_COMPLETE;
            end else if (n_used >= r_len) begin
                n_phase = PH_BAD;
                w_stat  = ST_CORRUPT;
            end
        end else if (w_req == REQ_END) begin
            if (g_v < GVOL_LOW && r_vforce) g_v = GVOL_FORCED;
            w_gvol = g_v;
            w_stat = ST_SUMMARY;
        end

        if (w_stat == ST_CORRUPT) w_bad = n_pat;
        w_mask  = n_mask;
        w_wants = ((n_phase == PH_FLAG) || (n_phase == PH_SKIP) ||
                   (n_phase == PH_CMD)  || (n_phase == PH_INFO)) && (w_req != REQ_END);

        // end of song clears the run state after the summary is formed
        if (w_req == REQ_END) begin
            n_mask    = '0;
            n_vforce  = 1'b1;
            n_phase   = PH_IDLE;
            n_skip    = '0;
            n_has_cmd = 1'b0;
        end
    end

    // population count of the reported mask
    always_comb begin
        w_count = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            w_count = w_count + COUNT_W'(w_mask[k]);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_en  <= '1;
            r_hdr_gvol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SET_LO, CFG_SET_MID_LO, CFG_SET_MID_HI, CFG_SET_HI: begin
                    for (int b = 0; b < 8; b++) begin
                        r_chan_en[{i_cfg_addr[1:0], 3'(b)}] <=
                            (i_cfg_wdata[b*8 +: 8] < SETTING_LIMIT);
                    end
                end
                CFG_GVOL: r_hdr_gvol <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_skip    <= '0;
            r_chan    <= '0;
            r_cmd     <= '0;
            r_has_cmd <= 1'b0;
            r_row     <= '0;
            r_used    <= '0;
            r_len     <= '0;
            r_pat     <= '0;
            r_mask    <= '0;
            r_vforce  <= 1'b1;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_chan    <= n_chan;
            r_cmd     <= n_cmd;
            r_has_cmd <= n_has_cmd;
            r_row     <= n_row;
            r_used    <= n_used;
            r_len     <= n_len;
            r_pat     <= n_pat;
            r_mask    <= n_mask;
            r_vforce  <= n_vforce;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {1'b0, w_bad, w_gvol, w_count, w_mask, w_wants};
            r_out_stat <= w_stat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_stat;

    // count field agrees with the mask it reports
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[38:33]) == 32'($countones(o_m_tdata[32:1]))))
        else $error("used channel count does not match mask");

    // volume only reported in a summary
    a_gvol_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_SUMMARY) |-> (o_m_tdata[46:39] == '0))
        else $error("global volume outside summary");

    // a corrupt or finished pattern, or a summary, takes no more bytes
    a_stop_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_CORRUPT || o_m_tuser == ST_COMPLETE ||
                        o_m_tuser == ST_SUMMARY)) |-> !o_m_tdata[0])
        else $error("wants_bytes set after pattern stopped");

    // end of song leaves a clean run state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_req == REQ_END) |=> (r_mask == '0 && r_vforce && r_phase == PH_IDLE))
        else $error("end of song did not clear run state");

    // idle parser has no skips and no command pending
    a_idle_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_skip == '0 && !r_has_cmd))
        else $error("idle parser holds event state");

endmodule

`default_nettype wire
